>>> hw/rtl/rdc_pkg.sv
`default_nettype none

package rdc_pkg;

  // Store sizes. Both are powers of two, so an element value maps onto its
  // count-store slot by keeping the low address bits.
  localparam int unsigned ELEMENT_DEPTH = 4096;
  localparam int unsigned VALUE_COUNT   = 4096;

  localparam int unsigned EIDX_W  = $clog2(ELEMENT_DEPTH);
  localparam int unsigned VIDX_W  = $clog2(VALUE_COUNT);
  localparam int unsigned CNT_W   = $clog2(ELEMENT_DEPTH + 1);

  // Fixed field widths of the ports.
  localparam int unsigned POS_W   = 12;
  localparam int unsigned VAL_W   = 12;
  localparam int unsigned RANGE_W = 13;

  // Epoch tag kept with every count entry; a stale tag reads as count zero.
  localparam int unsigned EPOCH_W = 4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_START,
    S_PLAN,
    S_ELEM,
    S_CNT,
    S_FINISH
  } rdc_state_e;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [CNT_W-1:0]   count;
  } rdc_cnt_entry_t;

  localparam int unsigned ENTRY_W = $bits(rdc_cnt_entry_t);

endpackage

`default_nettype wire

>>> hw/rtl/range_distinct_count_window.sv
`default_nettype none

// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    kind, position, value, range_left, range_right
// out       output     out_valid_o / out_ready_i  distinct_count, bad_range
// cfg       input      cfg_valid_i / cfg_ready_o  element_count
//
// A load is written as soon as it is taken. A query moves the window element by
// element; every move is a read of the element RAM, a read of the count RAM and a
// count write-back, in series.
// A query after a load restarts the window at element 0, and every
// sixteenth restart also sweeps the whole count RAM.
// After reset the same sweep runs before the first word is taken;
// configuration writes are taken at any time.
// A finished result waits in the output register, so a stall on the output
// holds the next query only when that query is done as well.
module range_distinct_count_window (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rdc_pkg::RANGE_W-1:0]   cfg_element_count_i,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [rdc_pkg::POS_W-1:0]     position_i,
  input  wire logic [rdc_pkg::VAL_W-1:0]     value_i,
  input  wire logic [rdc_pkg::RANGE_W-1:0]   range_left_i,
  input  wire logic [rdc_pkg::RANGE_W-1:0]   range_right_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rdc_pkg::RANGE_W-1:0]   distinct_count_o,
  output logic                               bad_range_o
);

  rdc_pkg::rdc_state_e state_q, state_d;

  // Control state.
  logic [rdc_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic [rdc_pkg::VIDX_W-1:0]  clr_q, clr_d;
  logic                        clr_resume_q, clr_resume_d;
  logic [rdc_pkg::RANGE_W-1:0] elem_cnt_q, elem_cnt_d;
  logic [rdc_pkg::EIDX_W-1:0]  win_left_q, win_left_d;
  logic [rdc_pkg::EIDX_W-1:0]  win_right_q, win_right_d;
  logic [rdc_pkg::CNT_W-1:0]   distinct_q, distinct_d;
  logic                        win_valid_q, win_valid_d;
  logic                        out_valid_q, out_valid_d;

  // Payload registers.
  logic [rdc_pkg::RANGE_W-1:0] qry_left_q, qry_left_d;
  logic [rdc_pkg::RANGE_W-1:0] qry_right_q, qry_right_d;
  logic [rdc_pkg::EIDX_W-1:0]  lo_q, lo_d;
  logic [rdc_pkg::EIDX_W-1:0]  hi_q, hi_d;
  logic                        step_add_q, step_add_d;
  logic [rdc_pkg::VIDX_W-1:0]  slot_q, slot_d;
  logic [rdc_pkg::RANGE_W-1:0] res_count_q, res_count_d;
  logic                        res_bad_q, res_bad_d;
  logic [rdc_pkg::RANGE_W-1:0] out_count_q, out_count_d;
  logic                        out_bad_q, out_bad_d;

  // Element RAM ports.
  logic                        er_we;
  logic [rdc_pkg::EIDX_W-1:0]  er_waddr;
  logic                        er_re;
  logic [rdc_pkg::EIDX_W-1:0]  er_raddr;
  logic [rdc_pkg::VAL_W-1:0]   er_rdata;

  // Count RAM ports.
  logic                        cr_we;
  logic [rdc_pkg::VIDX_W-1:0]  cr_waddr;
  rdc_pkg::rdc_cnt_entry_t     cr_wdata;
  logic                        cr_re;
  logic [rdc_pkg::VIDX_W-1:0]  cr_raddr;
  rdc_pkg::rdc_cnt_entry_t     cr_rdata;

  logic                        in_fire;
  logic                        bad;
  logic [rdc_pkg::CNT_W-1:0]   cur_count;

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == rdc_pkg::S_IDLE);
  assign in_fire          = in_valid_i && in_ready_o;
  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = out_count_q;
  assign bad_range_o      = out_bad_q;

  // The element store holds the raw 12-bit value; loads are taken only in idle,
  // so the write port never meets a window walk.
  rdc_ram #(
    .WIDTH (rdc_pkg::VAL_W),
    .DEPTH (rdc_pkg::ELEMENT_DEPTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (er_we),
    .waddr_i (er_waddr),
    .wdata_i (value_i),
    .re_i    (er_re),
    .raddr_i (er_raddr),
    .rdata_o (er_rdata)
  );

  // Each count entry carries the epoch in which it was last written. A restart
  // moves to a new epoch, which turns every older entry into a zero count
  // without touching the RAM. Besides reset, only an epoch wrap runs the sweep.
  rdc_ram #(
    .WIDTH (rdc_pkg::ENTRY_W),
    .DEPTH (rdc_pkg::VALUE_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cr_we),
    .waddr_i (cr_waddr),
    .wdata_i (cr_wdata),
    .re_i    (cr_re),
    .raddr_i (cr_raddr),
    .rdata_o (cr_rdata)
  );

  // The range check: a zero left end, a reversed range, or a right end past
  // either the configured element count or the store depth.
  assign bad = (qry_left_q == '0) ||
               (qry_left_q > qry_right_q) ||
               (qry_right_q > elem_cnt_q) ||
               (32'(qry_right_q) > 32'(rdc_pkg::ELEMENT_DEPTH));

  // Count read back for the current step; a stale epoch means zero.
  assign cur_count = (cr_rdata.epoch == epoch_q) ? cr_rdata.count : '0;

  always_comb begin
    state_d      = state_q;
    epoch_d      = epoch_q;
    clr_d        = clr_q;
    clr_resume_d = clr_resume_q;
    elem_cnt_d   = elem_cnt_q;
    win_left_d   = win_left_q;
    win_right_d  = win_right_q;
    distinct_d   = distinct_q;
    win_valid_d  = win_valid_q;
    qry_left_d   = qry_left_q;
    qry_right_d  = qry_right_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    step_add_d   = step_add_q;
    slot_d       = slot_q;
    res_count_d  = res_count_q;
    res_bad_d    = res_bad_q;
    out_count_d  = out_count_q;
    out_bad_d    = out_bad_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    er_we    = 1'b0;
    er_waddr = rdc_pkg::EIDX_W'(position_i);
    er_re    = 1'b0;
    er_raddr = '0;
    cr_we    = 1'b0;
    cr_waddr = slot_q;
    cr_wdata = '{epoch: epoch_q, count: '0};
    cr_re    = 1'b0;
    cr_raddr = rdc_pkg::VIDX_W'(er_rdata);

    if (cfg_valid_i && cfg_ready_o) begin
      elem_cnt_d = cfg_element_count_i;
    end

    case (state_q)
      rdc_pkg::S_CLEAR: begin
        cr_we    = 1'b1;
        cr_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == rdc_pkg::VIDX_W'(rdc_pkg::VALUE_COUNT - 1)) begin
          clr_resume_d = 1'b0;
          state_d      = clr_resume_q ? rdc_pkg::S_START : rdc_pkg::S_IDLE;
        end
      end

      rdc_pkg::S_IDLE: begin
        if (in_fire) begin
          if (kind_i == rdc_pkg::KIND_LOAD) begin
            // A load beyond the store is dropped and leaves the window alone.
            if (32'(position_i) < 32'(rdc_pkg::ELEMENT_DEPTH)) begin
              er_we       = 1'b1;
              win_valid_d = 1'b0;
            end
          end else begin
            qry_left_d  = range_left_i;
            qry_right_d = range_right_i;
            state_d     = rdc_pkg::S_CHECK;
          end
        end
      end

      rdc_pkg::S_CHECK: begin
        lo_d = rdc_pkg::EIDX_W'(qry_left_q - rdc_pkg::RANGE_W'(1));
        hi_d = rdc_pkg::EIDX_W'(qry_right_q - rdc_pkg::RANGE_W'(1));
        if (bad) begin
          res_count_d = '0;
          res_bad_d   = 1'b1;
          state_d     = rdc_pkg::S_FINISH;
        end else if (!win_valid_q) begin
          // Restart: empty window at element 0, counts wiped by a new epoch.
          win_left_d  = '0;
          win_right_d = '0;
          distinct_d  = '0;
          win_valid_d = 1'b1;
          epoch_d     = epoch_q + 1'b1;
          if (epoch_d == '0) begin
            clr_d        = '0;
            clr_resume_d = 1'b1;
            state_d      = rdc_pkg::S_CLEAR;
          end else begin
            state_d = rdc_pkg::S_START;
          end
        end else begin
          state_d = rdc_pkg::S_PLAN;
        end
      end

      rdc_pkg::S_START: begin
        er_re      = 1'b1;
        er_raddr   = '0;
        step_add_d = 1'b1;
        state_d    = rdc_pkg::S_ELEM;
      end

      rdc_pkg::S_PLAN: begin
        // Grow left, grow right, shrink left, shrink right, in that order.
        if (win_left_q > lo_q) begin
          win_left_d = win_left_q - 1'b1;
          er_re      = 1'b1;
          er_raddr   = win_left_q - 1'b1;
          step_add_d = 1'b1;
          state_d    = rdc_pkg::S_ELEM;
        end else if (win_right_q < hi_q) begin
          win_right_d = win_right_q + 1'b1;
          er_re       = 1'b1;
          er_raddr    = win_right_q + 1'b1;
          step_add_d  = 1'b1;
          state_d     = rdc_pkg::S_ELEM;
        end else if (win_left_q < lo_q) begin
          win_left_d = win_left_q + 1'b1;
          er_re      = 1'b1;
          er_raddr   = win_left_q;
          step_add_d = 1'b0;
          state_d    = rdc_pkg::S_ELEM;
        end else if (win_right_q > hi_q) begin
          win_right_d = win_right_q - 1'b1;
          er_re       = 1'b1;
          er_raddr    = win_right_q;
          step_add_d  = 1'b0;
          state_d     = rdc_pkg::S_ELEM;
        end else begin
          res_count_d = rdc_pkg::RANGE_W'(distinct_q);
          res_bad_d   = 1'b0;
          state_d     = rdc_pkg::S_FINISH;
        end
      end

      rdc_pkg::S_ELEM: begin
        cr_re    = 1'b1;
        cr_raddr = rdc_pkg::VIDX_W'(er_rdata);
        slot_d   = rdc_pkg::VIDX_W'(er_rdata);
        state_d  = rdc_pkg::S_CNT;
      end

      rdc_pkg::S_CNT: begin
        cr_waddr = slot_q;
        if (step_add_q) begin
          cr_we    = 1'b1;
          cr_wdata = '{epoch: epoch_q, count: cur_count + 1'b1};
          if (cur_count == '0) begin
            distinct_d = distinct_q + 1'b1;
          end
        end else if (cur_count != '0) begin
          cr_we    = 1'b1;
          cr_wdata = '{epoch: epoch_q, count: cur_count - 1'b1};
          if (cur_count == rdc_pkg::CNT_W'(1)) begin
            distinct_d = distinct_q - 1'b1;
          end
        end
        state_d = rdc_pkg::S_PLAN;
      end

      rdc_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_count_d = res_count_q;
          out_bad_d   = res_bad_q;
          state_d     = rdc_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rdc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rdc_pkg::S_CLEAR;
      epoch_q      <= '0;
      clr_q        <= '0;
      clr_resume_q <= 1'b0;
      elem_cnt_q   <= rdc_pkg::RANGE_W'(1);
      win_left_q   <= '0;
      win_right_q  <= '0;
      distinct_q   <= '0;
      win_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      epoch_q      <= epoch_d;
      clr_q        <= clr_d;
      clr_resume_q <= clr_resume_d;
      elem_cnt_q   <= elem_cnt_d;
      win_left_q   <= win_left_d;
      win_right_q  <= win_right_d;
      distinct_q   <= distinct_d;
      win_valid_q  <= win_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_left_q  <= qry_left_d;
    qry_right_q <= qry_right_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    step_add_q  <= step_add_d;
    slot_q      <= slot_d;
    res_count_q <= res_count_d;
    res_bad_q   <= res_bad_d;
    out_count_q <= out_count_d;
    out_bad_q   <= out_bad_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/rdc_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module rdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> bench/range_distinct_count_window_tb.sv
`default_nettype none

module range_distinct_count_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = rdc_pkg::ELEMENT_DEPTH;
  localparam int unsigned SLOTS        = rdc_pkg::VALUE_COUNT;
  localparam int unsigned RANGE_MAX    = (1 << rdc_pkg::RANGE_W) - 1;
  // Number of leading positions written with distinct values before the
  // random part; every good query of the random part stays inside them.
  localparam int unsigned FILL_LEN     = 128;
  // A load is written as soon as it is taken, so a short pause covers a load
  // still in flight when the last query word has come back.
  localparam int          DRAIN_CYCLES = 16;
  localparam int          TAIL_CYCLES  = 64;
  localparam int          LONG_HOLD    = 400;
  localparam int          N_PHASES     = 8;
  // Watchdog limit for the whole run.
  localparam longint      RUN_LIMIT_NS = 64'd40_000_000;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [rdc_pkg::RANGE_W-1:0] count;
    logic                        bad;
  } count_word_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_SETUP
  } row_op_e;

  // One row of the directed part. For a load, a and b are position and
  // value; for a query, left and right; for a setup row, a is the new
  // element count. A typed row carries its result, read straight off the
  // behavior; the others are predicted.
  typedef struct packed {
    row_op_e                     op;
    logic [rdc_pkg::RANGE_W-1:0] a;
    logic [rdc_pkg::RANGE_W-1:0] b;
    logic                        typed;
    count_word_t                 typed_word;
  } stim_row_t;

  logic                        clk_i               = 1'b0;
  logic                        rst_ni              = 1'b0;
  logic                        cfg_valid_i         = 1'b0;
  logic                        cfg_ready_o;
  logic [rdc_pkg::RANGE_W-1:0] cfg_element_count_i = '0;
  logic                        in_valid_i          = 1'b0;
  logic                        in_ready_o;
  logic                        kind_i              = rdc_pkg::KIND_LOAD;
  logic [rdc_pkg::POS_W-1:0]   position_i          = '0;
  logic [rdc_pkg::VAL_W-1:0]   value_i             = '0;
  logic [rdc_pkg::RANGE_W-1:0] range_left_i        = '0;
  logic [rdc_pkg::RANGE_W-1:0] range_right_i       = '0;
  logic                        out_valid_o;
  logic                        out_ready_i         = 1'b0;
  logic [rdc_pkg::RANGE_W-1:0] distinct_count_o;
  logic                        bad_range_o;

  range_distinct_count_window dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_element_count_i (cfg_element_count_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .position_i          (position_i),
    .value_i             (value_i),
    .range_left_i        (range_left_i),
    .range_right_i       (range_right_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .distinct_count_o    (distinct_count_o),
    .bad_range_o         (bad_range_o)
  );

  // Shared between the two sides: words still owed by the block, the error
  // tally, whether this phase runs without gaps, and a one-shot request for
  // the receiver to hold off for a long stretch.
  count_word_t pending_counts[$];
  int          mismatch_total = 0;
  bit          no_gaps        = 1'b0;
  bit          hold_request   = 1'b0;

  // Our own copy of the block state. The first FILL_LEN positions are
  // written before any query reaches past the first few positions, and no
  // good query ever reaches beyond them, so no window ever covers an
  // element that was never loaded.
  logic [rdc_pkg::VAL_W-1:0] elem_mem [DEPTH];
  int unsigned               occ [SLOTS];
  int unsigned               win_lo;
  int unsigned               win_hi;
  int unsigned               win_distinct;
  bit                        win_live;
  int unsigned               elem_limit;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Bring one more copy of the value at pos into the window.
  function automatic void tally_in(int unsigned pos);
    int unsigned slot;
    slot = elem_mem[pos] % SLOTS;
    occ[slot]++;
    if (occ[slot] == 1) win_distinct++;
  endfunction

  // Take one copy of the value at pos out of the window.
  function automatic void tally_out(int unsigned pos);
    int unsigned slot;
    slot = elem_mem[pos] % SLOTS;
    if (occ[slot] != 0) begin
      occ[slot]--;
      if (occ[slot] == 0) win_distinct--;
    end
  endfunction

  // Works out the word for one query and moves our window the way the block
  // does: grow left, grow right, shrink left, shrink right. A rejected range
  // leaves every piece of state alone.
  function automatic count_word_t predict_distinct(int unsigned left, int unsigned right);
    count_word_t word;
    int unsigned lo;
    int unsigned hi;
    word.count = '0;
    word.bad   = 1'b1;
    if (left == 0 || left > right || right > elem_limit || right > DEPTH) return word;
    lo = left - 1;
    hi = right - 1;
    // After a load the window restarts from scratch, holding element 0.
    if (!win_live) begin
      foreach (occ[i]) occ[i] = 0;
      win_distinct = 0;
      win_lo       = 0;
      win_hi       = 0;
      tally_in(0);
      win_live = 1'b1;
    end
    while (win_lo > lo) begin
      win_lo--;
      tally_in(win_lo);
    end
    while (win_hi < hi) begin
      win_hi++;
      tally_in(win_hi);
    end
    while (win_lo < lo) begin
      tally_out(win_lo);
      win_lo++;
    end
    while (win_hi > hi) begin
      tally_out(win_hi);
      win_hi--;
    end
    word.count = rdc_pkg::RANGE_W'(win_distinct);
    word.bad   = 1'b0;
    return word;
  endfunction

  function automatic stim_row_t stim_row(row_op_e op, int unsigned a, int unsigned b,
                                         bit typed = 1'b0, int unsigned cnt = 0,
                                         bit bad = 1'b0);
    stim_row_t row;
    row.op               = op;
    row.a                = rdc_pkg::RANGE_W'(a);
    row.b                = rdc_pkg::RANGE_W'(b);
    row.typed            = typed;
    row.typed_word.count = rdc_pkg::RANGE_W'(cnt);
    row.typed_word.bad   = bad;
    return row;
  endfunction

  // Offers one input word and waits for the block to take it. Valid is only
  // dropped when a gap is drawn, so back-to-back words never see valid
  // lowered and raised in the same step. The prediction is made at the edge
  // where the word is accepted.
  task automatic offer_word(input logic kind, input int unsigned pos, input int unsigned val,
                            input int unsigned left, input int unsigned right,
                            input bit typed = 1'b0, input count_word_t typed_word = '0);
    int          gap;
    count_word_t predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    position_i    <= rdc_pkg::POS_W'(pos);
    value_i       <= rdc_pkg::VAL_W'(val);
    range_left_i  <= rdc_pkg::RANGE_W'(left);
    range_right_i <= rdc_pkg::RANGE_W'(right);
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == rdc_pkg::KIND_LOAD) begin
      // Positions are 12 bits wide, so every load lands inside the store.
      elem_mem[pos % DEPTH] = rdc_pkg::VAL_W'(val);
      win_live              = 1'b0;
    end else begin
      predicted = predict_distinct(left, right);
      pending_counts.push_back(typed ? typed_word : predicted);
    end
  endtask

  // Changes the element count once the block has gone quiet: every owed word
  // has come back and a trailing load has had time to finish.
  task automatic write_limit(input int unsigned limit);
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_element_count_i <= rdc_pkg::RANGE_W'(limit);
    do @(posedge clk_i); while (!cfg_ready_o);
    elem_limit = limit & RANGE_MAX;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver side. It draws its own stall before each word and, when asked,
  // holds off for a long stretch so that the block backs up into its input.
  // Only a valid that is known high counts, so the edges inside reset are
  // never taken for a word.
  initial begin : collect_counts
    int          stall;
    count_word_t want;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = LONG_HOLD;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_counts.size() == 0) begin
        $display("%0t: word with nothing expected, count %0d bad_range %0b",
                 $time, distinct_count_o, bad_range_o);
        mismatch_total++;
      end else begin
        want = pending_counts.pop_front();
        if (distinct_count_o !== want.count) begin
          $display("%0t: distinct_count expected %0d, actual %0d",
                   $time, want.count, distinct_count_o);
          mismatch_total++;
        end
        if (bad_range_o !== want.bad) begin
          $display("%0t: bad_range expected %0b, actual %0b",
                   $time, want.bad, bad_range_o);
          mismatch_total++;
        end
      end
    end
  end

  // Sender side and run control.
  initial begin : drive_words
    stim_row_t   directed_rows[$];
    int unsigned limit;
    int unsigned base;
    int unsigned span;
    int unsigned load_pct;
    int unsigned n_items;
    int unsigned a;
    int unsigned b;
    int unsigned floor_bad;
    int unsigned pos;
    int unsigned val;

    elem_limit   = 1;
    win_lo       = 0;
    win_hi       = 0;
    win_distinct = 0;
    win_live     = 1'b0;
    foreach (occ[i]) occ[i] = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The element count starts at its reset value of one.
    // Rejected ranges come first, before anything is loaded, since they
    // touch no state at all.
    directed_rows.push_back(stim_row(ROW_QUERY, 0, 0, 1'b1, 0, 1'b1));
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 2, 1'b1, 0, 1'b1));
    directed_rows.push_back(stim_row(ROW_LOAD, 0, 4095));
    // First good query restarts the window on element 0.
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 1, 1'b1, 1, 1'b0));
    // Same range again: the window is already in place and does not move.
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 1, 1'b1, 1, 1'b0));
    directed_rows.push_back(stim_row(ROW_QUERY, 2, 1, 1'b1, 0, 1'b1));
    directed_rows.push_back(stim_row(ROW_LOAD, 1, 0));
    directed_rows.push_back(stim_row(ROW_LOAD, 2, 4095));
    directed_rows.push_back(stim_row(ROW_LOAD, 3, 2730));
    directed_rows.push_back(stim_row(ROW_LOAD, 4, 1365));
    directed_rows.push_back(stim_row(ROW_SETUP, 4096, 0));
    // Walk the window in every direction over a store with a repeated value.
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 5));
    directed_rows.push_back(stim_row(ROW_QUERY, 3, 4));
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 2));
    directed_rows.push_back(stim_row(ROW_QUERY, 5, 5));
    // A load in the middle of the loaded elements forces a restart on the next query.
    directed_rows.push_back(stim_row(ROW_LOAD, 2, 0));
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 5));
    // A zero element count rejects every range.
    directed_rows.push_back(stim_row(ROW_SETUP, 0, 0));
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 1, 1'b1, 0, 1'b1));
    // With the count at its top, ranges past the store depth are rejected.
    directed_rows.push_back(stim_row(ROW_SETUP, RANGE_MAX, 0));
    directed_rows.push_back(stim_row(ROW_QUERY, 1, DEPTH + 1, 1'b1, 0, 1'b1));
    directed_rows.push_back(stim_row(ROW_QUERY, DEPTH, RANGE_MAX, 1'b1, 0, 1'b1));
    directed_rows.push_back(stim_row(ROW_QUERY, RANGE_MAX, RANGE_MAX, 1'b1, 0, 1'b1));
    directed_rows.push_back(stim_row(ROW_SETUP, 5, 0));
    directed_rows.push_back(stim_row(ROW_QUERY, 1, 6, 1'b1, 0, 1'b1));
    directed_rows.push_back(stim_row(ROW_QUERY, 2, 5));

    // Fields that a word does not use carry random noise.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_LOAD: begin
          offer_word(rdc_pkg::KIND_LOAD, directed_rows[i].a, directed_rows[i].b,
                     $urandom_range(0, RANGE_MAX), $urandom_range(0, RANGE_MAX));
        end
        ROW_QUERY: begin
          offer_word(rdc_pkg::KIND_QUERY, $urandom_range(0, DEPTH - 1),
                     $urandom_range(0, SLOTS - 1), directed_rows[i].a, directed_rows[i].b,
                     directed_rows[i].typed, directed_rows[i].typed_word);
        end
        default: begin
          write_limit(directed_rows[i].a);
        end
      endcase
    end

    // Fill the leading positions with distinct values, so that the widest
    // good range holds as many distinct values as it has elements. After
    // this no good query below can touch an element that was never written.
    write_limit(DEPTH);
    no_gaps = 1'b1;
    for (int unsigned p = 0; p < FILL_LEN; p++) begin
      offer_word(rdc_pkg::KIND_LOAD, p, p, $urandom_range(0, RANGE_MAX),
                 $urandom_range(0, RANGE_MAX));
    end
    offer_word(rdc_pkg::KIND_QUERY, 0, 0, 1, FILL_LEN);
    offer_word(rdc_pkg::KIND_QUERY, 0, 0, FILL_LEN, FILL_LEN);
    offer_word(rdc_pkg::KIND_QUERY, 0, 0, 1, 1);

    // Random part, in phases. Each phase sets an element count and a focus
    // region [base, base + span) where most loads and good queries fall, so
    // that values repeat and the window moves a few dozen elements at a
    // time. Only one phase works at the far end of the filled region, and it
    // loads rarely, because each restart there walks the whole region.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin limit = DEPTH; base = 0; span = 32; load_pct = 25; n_items = 70; end
        1: begin limit = 1; base = 0; span = 1; load_pct = 20; n_items = 40; end
        2: begin
          limit = $urandom_range(2, 64); base = 0; span = limit; load_pct = 25; n_items = 60;
        end
        3: begin limit = 0; base = 0; span = 0; load_pct = 20; n_items = 30; end
        4: begin
          limit = RANGE_MAX; base = FILL_LEN - 48; span = 48; load_pct = 4; n_items = 40;
        end
        5: begin limit = DEPTH; base = 0; span = 16; load_pct = 25; n_items = 80; end
        6: begin
          limit = $urandom_range(1, DEPTH); base = 0; span = (limit < 40) ? limit : 40;
          load_pct = 25; n_items = 70;
        end
        default: begin limit = 100; base = 0; span = 100; load_pct = 20; n_items = 70; end
      endcase
      write_limit(limit);
      // Every third phase runs with neither side idling.
      no_gaps = (ph % 3 == 1);
      // Ask the receiver for its long hold while words keep coming.
      if (ph == 5) hold_request = 1'b1;
      // The lowest right end that the current count rejects.
      floor_bad = (limit < DEPTH) ? limit + 1 : DEPTH + 1;

      for (int unsigned k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < load_pct) begin
          if (span > 0 && $urandom_range(0, 3) != 0) begin
            pos = base + $urandom_range(0, span - 1);
            val = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, SLOTS - 1);
          end else begin
            pos = $urandom_range(0, DEPTH - 1);
            val = $urandom_range(0, SLOTS - 1);
          end
          offer_word(rdc_pkg::KIND_LOAD, pos, val, $urandom_range(0, RANGE_MAX),
                     $urandom_range(0, RANGE_MAX));
        end else begin
          if (span > 0 && $urandom_range(0, 99) < 85) begin
            a = $urandom_range(1, span);
            b = $urandom_range(1, span);
            if (a > b) begin
              pos = a;
              a   = b;
              b   = pos;
            end
            a = base + a;
            b = base + b;
          end else begin
            // Rejected ranges: a zero left end, ends in the wrong order, or a
            // right end past the element count or the store depth.
            case ($urandom_range(0, 2))
              0: begin
                a = 0;
                b = $urandom_range(0, RANGE_MAX);
              end
              1: begin
                a = $urandom_range(2, RANGE_MAX);
                b = $urandom_range(1, a - 1);
              end
              default: begin
                b = $urandom_range(floor_bad, RANGE_MAX);
                a = $urandom_range(1, b);
              end
            endcase
          end
          offer_word(rdc_pkg::KIND_QUERY, $urandom_range(0, DEPTH - 1),
                     $urandom_range(0, SLOTS - 1), a, b);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    // Give a stray extra word the chance to show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_ram.sv
hw/rtl/range_distinct_count_window.sv
bench/range_distinct_count_window_tb.sv
